// ===== hw/rtl/wfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Word frequency counter package
// Shared constants, the sequencer state type and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wfc_pkg;

  localparam int LINE_LEN_DEF = 64;
  localparam int MAX_REPORTS  = 32;
  localparam int PCT_SCALE    = 25600;
  localparam int PCT_W        = 15;

  localparam logic [7:0] CROSS_CHAR = 8'h2A;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  typedef enum logic [4:0] {
    S_LOAD,
    S_FIND,
    S_FIND_W,
    S_EMIT,
    S_LAST,
    S_LAST_W,
    S_CMP_INIT,
    S_I,
    S_I_W,
    S_J_A,
    S_J_B,
    S_J_C,
    S_END,
    S_END_W,
    S_XR,
    S_XW,
    S_PCT,
    S_DIV,
    S_FINAL
  } wfc_state_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Stored entries carry a crossed-out flag above the character byte.
  function automatic logic [7:0] eff_char(input logic [8:0] entry);
    return entry[8] ? CROSS_CHAR : entry[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wfc_in_if.sv =====
// ----------------------------------------------------------------------------
// Word frequency counter input channel
// Valid/ready channel that carries one character item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wfc_out_if.sv =====
// ----------------------------------------------------------------------------
// Word frequency counter output channel
// Valid/ready channel that carries one word report item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wfc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  word_start;
  logic [6:0]  word_length;
  logic [5:0]  occurrences;
  logic [6:0]  total_words;
  logic [14:0] percent_q8;
  logic        last_word;

  modport source (output valid, output word_start, output word_length, output occurrences,
                  output total_words, output percent_q8, output last_word, input ready);
  modport sink   (input valid, input word_start, input word_length, input occurrences,
                  input total_words, input percent_q8, input last_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wfc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/word_frequency_counter_core.sv =====
// ----------------------------------------------------------------------------
// Word frequency counter core
// Loads a text line and reports each distinct word with its frequency.
// ----------------------------------------------------------------------------
// The block takes one character item per cycle until the item marked end of
// line, then stops taking items and analyzes the stored line, emitting one
// report item per distinct word in order of first appearance, at most
// MAX_REPORTS per line. All analysis runs through one single-port line
// memory, so the analysis time grows with the square of the line length.
// For each word the block scans the line for its start and end, checks every
// later candidate position, compares it character by character, checks the
// end of the match, crosses out each match and the word itself, and runs a
// bit-serial divide for the percentage. Results wait in an output register,
// so a slow sink stalls the analysis only when a second report is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module word_frequency_counter_core
  import wfc_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input wire logic clk,
  input wire logic rst,
  wfc_in_if.sink   in_ch,
  wfc_out_if.source out_ch
);

  localparam int AW = $clog2(LINE_LEN);
  localparam int PW = $clog2(LINE_LEN + 2);
  localparam int SW = PW + 1;
  localparam int NW = PCT_W + PW;
  localparam int DW = $clog2(NW + 1);
  localparam int RW = $clog2(MAX_REPORTS + 1);

  wfc_state_t state, state_next;

  logic [PW-1:0] fill, fill_next;
  logic [PW-1:0] len, len_next;
  logic          zero_seen, zero_seen_next;
  logic [PW-1:0] spaces, spaces_next;
  logic [PW-1:0] p, p_next;
  logic [PW-1:0] first, first_next;
  logic [PW-1:0] last, last_next;
  logic [PW-1:0] size, size_next;
  logic [PW-1:0] i, i_next;
  logic [PW-1:0] j, j_next;
  logic [7:0]    wbyte, wbyte_next;
  logic [PW-1:0] occ, occ_next;
  logic [RW-1:0] count, count_next;
  logic [NW-1:0] dq, dq_next;
  logic [PW-1:0] rem, rem_next;
  logic [DW-1:0] dc, dc_next;

  logic          held_valid, held_valid_next;
  logic [PW-1:0] held_first, held_first_next;
  logic [PW-1:0] held_size, held_size_next;
  logic [PW-1:0] held_occ, held_occ_next;
  logic [PCT_W-1:0] held_pct, held_pct_next;

  logic        ovalid, ovalid_next;
  logic [5:0]  o_start, o_start_next;
  logic [6:0]  o_length, o_length_next;
  logic [5:0]  o_occ, o_occ_next;
  logic [6:0]  o_words, o_words_next;
  logic [14:0] o_pct, o_pct_next;
  logic        o_last, o_last_next;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [8:0]    mem_wdata;
  logic [8:0]    mem_rdata;

  logic [7:0]    eff;
  logic [PW-1:0] words;
  logic [SW-1:0] ipj, isz;
  logic [PW:0]   div_t;
  logic [NW-1:0] dq_step;
  logic [PW-1:0] rem_step;
  logic          out_free;

  wfc_ram #(.WIDTH(9), .DEPTH(LINE_LEN)) u_line (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign eff      = eff_char(mem_rdata);
  assign words    = spaces + PW'(1);
  assign ipj      = SW'(i) + SW'(j);
  assign isz      = SW'(i) + SW'(size);
  assign out_free = !ovalid || out_ch.ready;

  assign div_t = {rem, dq[NW-1]};
  always_comb begin
    if (div_t >= (PW+1)'(words)) begin
      rem_step = PW'(div_t - (PW+1)'(words));
      dq_step  = {dq[NW-2:0], 1'b1};
    end else begin
      rem_step = PW'(div_t);
      dq_step  = {dq[NW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    len_next        = len;
    zero_seen_next  = zero_seen;
    spaces_next     = spaces;
    p_next          = p;
    first_next      = first;
    last_next       = last;
    size_next       = size;
    i_next          = i;
    j_next          = j;
    wbyte_next      = wbyte;
    occ_next        = occ;
    count_next      = count;
    dq_next         = dq;
    rem_next        = rem;
    dc_next         = dc;
    held_valid_next = held_valid;
    held_first_next = held_first;
    held_size_next  = held_size;
    held_occ_next   = held_occ;
    held_pct_next   = held_pct;
    ovalid_next     = ovalid && !out_ch.ready;
    o_start_next    = o_start;
    o_length_next   = o_length;
    o_occ_next      = o_occ;
    o_words_next    = o_words;
    o_pct_next      = o_pct;
    o_last_next     = o_last;
    mem_we          = 1'b0;
    mem_addr        = '0;
    mem_wdata       = '0;
    in_ch.ready     = 1'b0;

    unique case (state)
      S_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (fill < PW'(LINE_LEN)) begin
            mem_we    = 1'b1;
            mem_addr  = AW'(fill);
            mem_wdata = {1'b0, in_ch.char_byte};
            fill_next = fill + PW'(1);
            if (!zero_seen) begin
              if (in_ch.char_byte == NUL_CHAR) begin
                zero_seen_next = 1'b1;
              end else begin
                len_next = fill + PW'(1);
                if (in_ch.char_byte == SPACE_CHAR) begin
                  spaces_next = spaces + PW'(1);
                end
              end
            end
          end
          if (in_ch.end_of_line) begin
            p_next     = '0;
            count_next = '0;
            state_next = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (count == RW'(MAX_REPORTS) || p >= len) begin
          state_next = S_FINAL;
        end else begin
          mem_addr   = AW'(p);
          state_next = S_FIND_W;
        end
      end
      S_FIND_W: begin
        if (is_letter(eff)) begin
          first_next = p;
          state_next = held_valid ? S_EMIT : S_LAST;
        end else begin
          p_next     = p + PW'(1);
          state_next = S_FIND;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_next     = 1'b1;
          o_start_next    = 6'(held_first);
          o_length_next   = 7'(held_size);
          o_occ_next      = 6'(held_occ);
          o_words_next    = 7'(words);
          o_pct_next      = held_pct;
          o_last_next     = 1'b0;
          held_valid_next = 1'b0;
          state_next      = S_LAST;
        end
      end
      S_LAST: begin
        if (p >= len) begin
          last_next  = len;
          state_next = S_CMP_INIT;
        end else begin
          mem_addr   = AW'(p);
          state_next = S_LAST_W;
        end
      end
      S_LAST_W: begin
        if (eff == SPACE_CHAR) begin
          last_next  = p;
          state_next = S_CMP_INIT;
        end else begin
          p_next     = p + PW'(1);
          state_next = S_LAST;
        end
      end
      S_CMP_INIT: begin
        size_next  = last - first;
        occ_next   = PW'(1);
        i_next     = last + PW'(1);
        state_next = S_I;
      end
      S_I: begin
        if (i >= len) begin
          p_next     = first;
          state_next = S_XW;
        end else begin
          mem_addr   = AW'(i - PW'(1));
          state_next = S_I_W;
        end
      end
      S_I_W: begin
        if (eff == SPACE_CHAR) begin
          j_next     = '0;
          state_next = S_J_A;
        end else begin
          i_next     = i + PW'(1);
          state_next = S_I;
        end
      end
      S_J_A: begin
        if (j == size) begin
          state_next = S_END;
        end else begin
          mem_addr   = AW'(first + j);
          state_next = S_J_B;
        end
      end
      S_J_B: begin
        wbyte_next = eff;
        if (ipj >= SW'(len)) begin
          i_next     = i + PW'(1);
          state_next = S_I;
        end else begin
          mem_addr   = AW'(ipj);
          state_next = S_J_C;
        end
      end
      S_J_C: begin
        if (eff == wbyte) begin
          j_next     = j + PW'(1);
          state_next = S_J_A;
        end else begin
          i_next     = i + PW'(1);
          state_next = S_I;
        end
      end
      S_END: begin
        if (isz == SW'(len)) begin
          occ_next   = occ + PW'(1);
          p_next     = i;
          state_next = S_XR;
        end else begin
          mem_addr   = AW'(isz);
          state_next = S_END_W;
        end
      end
      S_END_W: begin
        if (eff == SPACE_CHAR) begin
          occ_next   = occ + PW'(1);
          p_next     = i;
          state_next = S_XR;
        end else begin
          i_next     = i + PW'(1);
          state_next = S_I;
        end
      end
      S_XR: begin
        if (SW'(p) > isz || p >= len) begin
          i_next     = i + PW'(1);
          state_next = S_I;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = AW'(p);
          mem_wdata = {1'b1, NUL_CHAR};
          p_next    = p + PW'(1);
        end
      end
      S_XW: begin
        if (p > last || p >= len) begin
          state_next = S_PCT;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = AW'(p);
          mem_wdata = {1'b1, NUL_CHAR};
          p_next    = p + PW'(1);
        end
      end
      S_PCT: begin
        dq_next    = NW'(occ) * NW'(PCT_SCALE);
        rem_next   = '0;
        dc_next    = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        dq_next  = dq_step;
        rem_next = rem_step;
        dc_next  = dc + DW'(1);
        if (dc == DW'(NW - 1)) begin
          held_valid_next = 1'b1;
          held_first_next = first;
          held_size_next  = size;
          held_occ_next   = occ;
          held_pct_next   = dq_step[PCT_W-1:0];
          count_next      = count + RW'(1);
          p_next          = first;
          state_next      = S_FIND;
        end
      end
      S_FINAL: begin
        if (!held_valid || out_free) begin
          if (held_valid) begin
            ovalid_next   = 1'b1;
            o_start_next  = 6'(held_first);
            o_length_next = 7'(held_size);
            o_occ_next    = 6'(held_occ);
            o_words_next  = 7'(words);
            o_pct_next    = held_pct;
            o_last_next   = 1'b1;
          end
          held_valid_next = 1'b0;
          fill_next       = '0;
          len_next        = '0;
          zero_seen_next  = 1'b0;
          spaces_next     = '0;
          state_next      = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      fill       <= '0;
      len        <= '0;
      zero_seen  <= 1'b0;
      spaces     <= '0;
      count      <= '0;
      held_valid <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      len        <= len_next;
      zero_seen  <= zero_seen_next;
      spaces     <= spaces_next;
      count      <= count_next;
      held_valid <= held_valid_next;
      ovalid     <= ovalid_next;
    end
    p          <= p_next;
    first      <= first_next;
    last       <= last_next;
    size       <= size_next;
    i          <= i_next;
    j          <= j_next;
    wbyte      <= wbyte_next;
    occ        <= occ_next;
    dq         <= dq_next;
    rem        <= rem_next;
    dc         <= dc_next;
    held_first <= held_first_next;
    held_size  <= held_size_next;
    held_occ   <= held_occ_next;
    held_pct   <= held_pct_next;
    o_start    <= o_start_next;
    o_length   <= o_length_next;
    o_occ      <= o_occ_next;
    o_words    <= o_words_next;
    o_pct      <= o_pct_next;
    o_last     <= o_last_next;
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.word_start  = o_start;
  assign out_ch.word_length = o_length;
  assign out_ch.occurrences = o_occ;
  assign out_ch.total_words = o_words;
  assign out_ch.percent_q8  = o_pct;
  assign out_ch.last_word   = o_last;

endmodule

`default_nettype wire

// ===== hw/rtl/wfc_checker.sv =====
// ----------------------------------------------------------------------------
// Word frequency counter checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_eol,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_occ,
  input wire logic [6:0]  out_length,
  input wire logic [6:0]  out_words,
  input wire logic [14:0] out_pct
);

  a_busy_after_line: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_eol |=> !in_ready)
    else $error("Core took an item right after the end of a line.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pct) && $stable(out_occ))
    else $error("Stalled report item changed.");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_length != 7'd0 && out_occ != 6'd0)
    else $error("Report item has an empty word or no occurrences.");

  a_words_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_words != 7'd0)
    else $error("Report item has a zero word total.");

endmodule

bind word_frequency_counter_core wfc_checker u_wfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_eol    (in_ch.end_of_line),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_occ   (out_ch.occurrences),
  .out_length(out_ch.word_length),
  .out_words (out_ch.total_words),
  .out_pct   (out_ch.percent_q8)
);

`default_nettype wire
